// File: src/hmac_sha256_tls_prf_assert.svh
// Assertion macros of the HMAC-SHA256 and TLS PRF engine.
`ifndef HMAC_SHA256_TLS_PRF_ASSERT_SVH
`define HMAC_SHA256_TLS_PRF_ASSERT_SVH
`define HSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsp assertion failed");
`define HSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsp assertion failed");
`endif

// File: src/hsp_pkg.sv
// Shared types, constants and SHA-256 tables of the HMAC-SHA256 and TLS PRF engine.
package hsp_pkg;
	localparam int SEED_MAX = 128;
	localparam int OUT_MAX = 256;
	localparam int OUT_CAP = (OUT_MAX < 256) ? OUT_MAX : 256;
	localparam int SEED_WORDS = (SEED_MAX + 7) / 8;
	localparam int SW_W = (SEED_WORDS > 1) ? $clog2(SEED_WORDS) : 1;
	localparam int SL_W = $clog2(SEED_MAX + 1);
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_OUT_LEN = 1'b1;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  valid_bytes;
		logic        final_res;
		logic        status;
	} rsp_t;

	typedef enum logic [3:0] {
		SRC_IN, SRC_KEY, SRC_KEY_IPAD, SRC_KEY_OPAD, SRC_SEED,
		SRC_CHAIN, SRC_INNER, SRC_PAD, SRC_ZERO, SRC_LEN
	} src_t;

	typedef struct packed {
		logic       take;
		logic       hinit;
		logic       feed;
		src_t       src;
		logic [7:0] idx;
		logic       latch_len;
		logic       key_clear;
		logic       key_wr;
		logic       key_load;
		logic       inner_save;
		logic       chain_save;
		logic       seed_wr;
		logic       out_load;
		logic       out_zero;
		logic [3:0] out_vb;
		logic       out_final;
		logic       out_status;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic [5:0] pos;
		logic       out_free;
	} sts_t;

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		case (i)
			6'd0: return 32'h428a2f98;   6'd1: return 32'h71374491;
			6'd2: return 32'hb5c0fbcf;   6'd3: return 32'he9b5dba5;
			6'd4: return 32'h3956c25b;   6'd5: return 32'h59f111f1;
			6'd6: return 32'h923f82a4;   6'd7: return 32'hab1c5ed5;
			6'd8: return 32'hd807aa98;   6'd9: return 32'h12835b01;
			6'd10: return 32'h243185be;  6'd11: return 32'h550c7dc3;
			6'd12: return 32'h72be5d74;  6'd13: return 32'h80deb1fe;
			6'd14: return 32'h9bdc06a7;  6'd15: return 32'hc19bf174;
			6'd16: return 32'he49b69c1;  6'd17: return 32'hefbe4786;
			6'd18: return 32'h0fc19dc6;  6'd19: return 32'h240ca1cc;
			6'd20: return 32'h2de92c6f;  6'd21: return 32'h4a7484aa;
			6'd22: return 32'h5cb0a9dc;  6'd23: return 32'h76f988da;
			6'd24: return 32'h983e5152;  6'd25: return 32'ha831c66d;
			6'd26: return 32'hb00327c8;  6'd27: return 32'hbf597fc7;
			6'd28: return 32'hc6e00bf3;  6'd29: return 32'hd5a79147;
			6'd30: return 32'h06ca6351;  6'd31: return 32'h14292967;
			6'd32: return 32'h27b70a85;  6'd33: return 32'h2e1b2138;
			6'd34: return 32'h4d2c6dfc;  6'd35: return 32'h53380d13;
			6'd36: return 32'h650a7354;  6'd37: return 32'h766a0abb;
			6'd38: return 32'h81c2c92e;  6'd39: return 32'h92722c85;
			6'd40: return 32'ha2bfe8a1;  6'd41: return 32'ha81a664b;
			6'd42: return 32'hc24b8b70;  6'd43: return 32'hc76c51a3;
			6'd44: return 32'hd192e819;  6'd45: return 32'hd6990624;
			6'd46: return 32'hf40e3585;  6'd47: return 32'h106aa070;
			6'd48: return 32'h19a4c116;  6'd49: return 32'h1e376c08;
			6'd50: return 32'h2748774c;  6'd51: return 32'h34b0bcb5;
			6'd52: return 32'h391c0cb3;  6'd53: return 32'h4ed8aa4a;
			6'd54: return 32'h5b9cca4f;  6'd55: return 32'h682e6ff3;
			6'd56: return 32'h748f82ee;  6'd57: return 32'h78a5636f;
			6'd58: return 32'h84c87814;  6'd59: return 32'h8cc70208;
			6'd60: return 32'h90befffa;  6'd61: return 32'ha4506ceb;
			6'd62: return 32'hbef9a3f7;  6'd63: return 32'hc67178f2;
			default: return 32'h0;
		endcase
	endfunction
endpackage

// File: src/hsp_ctrl.sv
// Sequencer of the HMAC-SHA256 and TLS PRF engine: key, message and PRF control.
module hsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [8:0]    cfg_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic          req_opcode,
	input  logic          req_last,
	input  hsp_pkg::sts_t sts,
	output hsp_pkg::cmd_t cmd
);
	import hsp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_KEY_BYTE, S_CLOSE, S_KEY_SET, S_MSG_START, S_MSG_BYTE,
		S_FEED, S_FIN_PAD, S_FIN_ZERO, S_FIN_LEN, S_FIN_WAIT,
		S_H_START, S_H_CHAIN, S_H_SEED, S_H_IFIN, S_H_INNER, S_H_IH, S_H_OFIN,
		S_TAG_OUT, S_PRF_START, S_SAVE_A, S_EMIT, S_OUT_ERR, S_OUT_EMPTY
	} state_t;

	state_t state_q, state_d, ret_q, ret_d, hret_q, hret_d;
	logic mode_q, mode_d;
	logic [8:0] out_len_q, out_len_d;
	logic op_q, op_d, last_q, last_d;
	logic [6:0] klen_q, klen_d, ek;
	logic closed_q, closed_d, msg_q, msg_d, run_mode_q, run_mode_d;
	logic [SL_W-1:0] slen_q, slen_d;
	logic ovf_q, ovf_d, ovf_n, full;
	logic [8:0] cnt_q, cnt_d, n_q, n_d, want_q, want_d, pos_q, pos_d, rem;
	src_t src_q, src_d;
	logic use_chain_q, use_chain_d, use_seed_q, use_seed_d;
	logic [3:0] vb;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		hret_d = hret_q;
		mode_d = mode_q;
		out_len_d = out_len_q;
		op_d = op_q;
		last_d = last_q;
		klen_d = klen_q;
		closed_d = closed_q;
		msg_d = msg_q;
		run_mode_d = run_mode_q;
		slen_d = slen_q;
		ovf_d = ovf_q;
		cnt_d = cnt_q;
		n_d = n_q;
		want_d = want_q;
		pos_d = pos_q;
		src_d = src_q;
		use_chain_d = use_chain_q;
		use_seed_d = use_seed_q;
		cmd = '0;
		cmd.src = SRC_ZERO;
		req_stall = (state_q != S_IDLE);
		ek = closed_q ? 7'd0 : klen_q;
		full = (slen_q == SL_W'(SEED_MAX));
		ovf_n = ovf_q | full;
		rem = want_q - pos_q;
		vb = (rem > 9'd8) ? 4'd8 : rem[3:0];

		if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_d = cfg_data[0];
				REG_OUT_LEN: out_len_d = cfg_data;
				default: mode_d = mode_q;
			endcase
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d = req_opcode;
					last_d = req_last;
					cmd.take = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (!op_q) begin
					if (closed_q) begin
						cmd.key_clear = 1'b1;
						closed_d = 1'b0;
						msg_d = 1'b0;
					end
					if (ek < 7'd64) begin
						cmd.key_wr = 1'b1;
						cmd.idx = {2'b00, ek[5:0]};
						klen_d = ek + 7'd1;
						state_d = last_q ? S_CLOSE : S_IDLE;
					end else if (ek == 7'd64) begin
						cmd.hinit = 1'b1;
						src_d = SRC_KEY;
						cnt_d = '0;
						n_d = 9'd64;
						ret_d = S_KEY_BYTE;
						state_d = S_FEED;
					end else begin
						state_d = S_KEY_BYTE;
					end
				end else begin
					state_d = closed_q ? S_MSG_START : S_CLOSE;
				end
			end
			S_KEY_BYTE: begin
				if (!sts.busy) begin
					cmd.feed = 1'b1;
					cmd.src = SRC_IN;
					klen_d = 7'd65;
					state_d = last_q ? S_CLOSE : S_IDLE;
				end
			end
			S_CLOSE: begin
				if (klen_q > 7'd64) begin
					ret_d = S_KEY_SET;
					state_d = S_FIN_PAD;
				end else begin
					closed_d = 1'b1;
					state_d = op_q ? S_MSG_START : S_IDLE;
				end
			end
			S_KEY_SET: begin
				cmd.key_load = 1'b1;
				closed_d = 1'b1;
				state_d = op_q ? S_MSG_START : S_IDLE;
			end
			S_MSG_START: begin
				state_d = S_MSG_BYTE;
				if (!msg_q) begin
					msg_d = 1'b1;
					run_mode_d = mode_q;
					slen_d = '0;
					ovf_d = 1'b0;
					if (!mode_q) begin
						cmd.hinit = 1'b1;
						src_d = SRC_KEY_IPAD;
						cnt_d = '0;
						n_d = 9'd64;
						ret_d = S_MSG_BYTE;
						state_d = S_FEED;
					end
				end
			end
			S_MSG_BYTE: begin
				if (!run_mode_q) begin
					if (!sts.busy) begin
						cmd.feed = 1'b1;
						cmd.src = SRC_IN;
						if (last_q) begin
							msg_d = 1'b0;
							hret_d = S_TAG_OUT;
							state_d = S_H_IFIN;
						end else begin
							state_d = S_IDLE;
						end
					end
				end else begin
					if (!full) begin
						cmd.seed_wr = 1'b1;
						cmd.idx = 8'(slen_q);
						slen_d = slen_q + 1'b1;
					end
					ovf_d = ovf_n;
					if (last_q) begin
						msg_d = 1'b0;
						state_d = ovf_n ? S_OUT_ERR : S_PRF_START;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FEED: begin
				if (!sts.busy) begin
					cmd.feed = 1'b1;
					cmd.src = src_q;
					cmd.idx = cnt_q[7:0];
					cnt_d = cnt_q + 9'd1;
					if (cnt_q + 9'd1 == n_q) begin
						state_d = ret_q;
					end
				end
			end
			S_FIN_PAD: begin
				if (!sts.busy) begin
					cmd.feed = 1'b1;
					cmd.src = SRC_PAD;
					cmd.latch_len = 1'b1;
					state_d = S_FIN_ZERO;
				end
			end
			S_FIN_ZERO: begin
				if (!sts.busy) begin
					if (sts.pos == 6'd56) begin
						cnt_d = '0;
						state_d = S_FIN_LEN;
					end else begin
						cmd.feed = 1'b1;
						cmd.src = SRC_ZERO;
					end
				end
			end
			S_FIN_LEN: begin
				if (!sts.busy) begin
					cmd.feed = 1'b1;
					cmd.src = SRC_LEN;
					cmd.idx = cnt_q[7:0];
					cnt_d = cnt_q + 9'd1;
					if (cnt_q[2:0] == 3'd7) begin
						state_d = S_FIN_WAIT;
					end
				end
			end
			S_FIN_WAIT: begin
				if (!sts.busy) begin
					cnt_d = '0;
					state_d = ret_q;
				end
			end
			S_H_START: begin
				cmd.hinit = 1'b1;
				src_d = SRC_KEY_IPAD;
				cnt_d = '0;
				n_d = 9'd64;
				ret_d = S_H_CHAIN;
				state_d = S_FEED;
			end
			S_H_CHAIN: begin
				if (use_chain_q) begin
					src_d = SRC_CHAIN;
					cnt_d = '0;
					n_d = 9'd32;
					ret_d = S_H_SEED;
					state_d = S_FEED;
				end else begin
					state_d = S_H_SEED;
				end
			end
			S_H_SEED: begin
				if (use_seed_q && (slen_q != '0)) begin
					src_d = SRC_SEED;
					cnt_d = '0;
					n_d = 9'(slen_q);
					ret_d = S_H_IFIN;
					state_d = S_FEED;
				end else begin
					state_d = S_H_IFIN;
				end
			end
			S_H_IFIN: begin
				ret_d = S_H_INNER;
				state_d = S_FIN_PAD;
			end
			S_H_INNER: begin
				cmd.inner_save = 1'b1;
				cmd.hinit = 1'b1;
				src_d = SRC_KEY_OPAD;
				cnt_d = '0;
				n_d = 9'd64;
				ret_d = S_H_IH;
				state_d = S_FEED;
			end
			S_H_IH: begin
				src_d = SRC_INNER;
				cnt_d = '0;
				n_d = 9'd32;
				ret_d = S_H_OFIN;
				state_d = S_FEED;
			end
			S_H_OFIN: begin
				ret_d = hret_q;
				state_d = S_FIN_PAD;
			end
			S_TAG_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.idx = cnt_q[7:0];
					cmd.out_vb = 4'd8;
					cmd.out_final = (cnt_q[1:0] == 2'd3);
					cnt_d = cnt_q + 9'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_d = S_IDLE;
					end
				end
			end
			S_PRF_START: begin
				want_d = (out_len_q > 9'(OUT_CAP)) ? 9'(OUT_CAP) : out_len_q;
				pos_d = '0;
				if (out_len_q == 9'd0) begin
					state_d = S_OUT_EMPTY;
				end else begin
					use_chain_d = 1'b0;
					use_seed_d = 1'b1;
					hret_d = S_SAVE_A;
					state_d = S_H_START;
				end
			end
			S_SAVE_A: begin
				cmd.chain_save = 1'b1;
				use_chain_d = 1'b1;
				use_seed_d = 1'b1;
				hret_d = S_EMIT;
				state_d = S_H_START;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.idx = cnt_q[7:0];
					cmd.out_vb = vb;
					cmd.out_final = (rem <= 9'd8);
					pos_d = pos_q + 9'(vb);
					cnt_d = cnt_q + 9'd1;
					if (rem <= 9'd8) begin
						state_d = S_IDLE;
					end else if (cnt_q[1:0] == 2'd3) begin
						use_chain_d = 1'b1;
						use_seed_d = 1'b0;
						hret_d = S_SAVE_A;
						state_d = S_H_START;
					end
				end
			end
			S_OUT_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = 1'b1;
					cmd.out_final = 1'b1;
					cmd.out_status = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_OUT_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = 1'b1;
					cmd.out_final = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			hret_q <= S_IDLE;
			mode_q <= 1'b0;
			out_len_q <= 9'd48;
			op_q <= 1'b0;
			last_q <= 1'b0;
			klen_q <= '0;
			closed_q <= 1'b0;
			msg_q <= 1'b0;
			run_mode_q <= 1'b0;
			slen_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
			n_q <= '0;
			want_q <= '0;
			pos_q <= '0;
			src_q <= SRC_ZERO;
			use_chain_q <= 1'b0;
			use_seed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			hret_q <= hret_d;
			mode_q <= mode_d;
			out_len_q <= out_len_d;
			op_q <= op_d;
			last_q <= last_d;
			klen_q <= klen_d;
			closed_q <= closed_d;
			msg_q <= msg_d;
			run_mode_q <= run_mode_d;
			slen_q <= slen_d;
			ovf_q <= ovf_d;
			cnt_q <= cnt_d;
			n_q <= n_d;
			want_q <= want_d;
			pos_q <= pos_d;
			src_q <= src_d;
			use_chain_q <= use_chain_d;
			use_seed_q <= use_seed_d;
		end
	end
endmodule

// File: src/hsp_datapath.sv
// Datapath of the HMAC-SHA256 and TLS PRF engine: key, seed, SHA-256 rounds, result register.
`include "hmac_sha256_tls_prf_assert.svh"
module hsp_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    data_byte,
	input  hsp_pkg::cmd_t cmd,
	output hsp_pkg::sts_t sts,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output hsp_pkg::rsp_t rsp
);
	import hsp_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [7:0] in_byte_q;
	logic [63:0][7:0] key_q, key_nxt;
	logic [7:0][7:0] seed_q [SEED_WORDS];
	logic [31:0][7:0] chain_q, inner_q, dig;
	logic [3:0][63:0] dig_w;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [3:0][7:0] w_q [16];
	logic [63:0] bits_q;
	logic [7:0][7:0] len_q;
	logic busy_q;
	logic [6:0] rnd_q;
	logic out_valid_q;
	rsp_t rsp_q;
	logic [7:0] fbyte, kbyte;
	logic [5:0] pos;
	logic [31:0] t1, t2, wnew;
	logic [63:0] keep;

	assign pos = bits_q[8:3];
	assign dig = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
	assign dig_w = dig;
	assign kbyte = key_q[6'd63 - cmd.idx[5:0]];
	assign keep = ~({64{1'b1}} >> {cmd.out_vb, 3'b000});

	always_comb begin
		case (cmd.src)
			SRC_IN: fbyte = in_byte_q;
			SRC_KEY: fbyte = kbyte;
			SRC_KEY_IPAD: fbyte = kbyte ^ IPAD;
			SRC_KEY_OPAD: fbyte = kbyte ^ OPAD;
			SRC_SEED: fbyte = seed_q[cmd.idx[3 +: SW_W]][3'd7 - cmd.idx[2:0]];
			SRC_CHAIN: fbyte = chain_q[5'd31 - cmd.idx[4:0]];
			SRC_INNER: fbyte = inner_q[5'd31 - cmd.idx[4:0]];
			SRC_PAD: fbyte = 8'h80;
			SRC_LEN: fbyte = len_q[3'd7 - cmd.idx[2:0]];
			default: fbyte = 8'h00;
		endcase
	end

	always_comb begin
		key_nxt = cmd.key_clear ? '0 : key_q;
		if (cmd.key_wr) begin
			key_nxt[6'd63 - cmd.idx[5:0]] = in_byte_q;
		end
		if (cmd.key_load) begin
			key_nxt = {dig, 256'b0};
		end
	end

	always_comb begin
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + sha_k(rnd_q[5:0]) + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		wnew = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9]
			+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			busy_q <= 1'b0;
			rnd_q <= '0;
			bits_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= SHA_IV[i];
			end
		end else begin
			key_q <= key_nxt;
			if (cmd.hinit) begin
				busy_q <= 1'b0;
				bits_q <= '0;
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= SHA_IV[i];
				end
			end else if (cmd.feed) begin
				bits_q <= bits_q + 64'd8;
				if (pos == 6'd63) begin
					busy_q <= 1'b1;
					rnd_q <= '0;
				end
			end else if (busy_q) begin
				if (rnd_q == 7'd64) begin
					busy_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_byte_q <= data_byte;
		end
		if (cmd.latch_len) begin
			len_q <= bits_q;
		end
		if (cmd.seed_wr) begin
			seed_q[cmd.idx[3 +: SW_W]][3'd7 - cmd.idx[2:0]] <= in_byte_q;
		end
		if (cmd.chain_save) begin
			chain_q <= dig;
		end
		if (cmd.inner_save) begin
			inner_q <= dig;
		end
		if (cmd.feed && !cmd.hinit) begin
			w_q[pos[5:2]][2'd3 - pos[1:0]] <= fbyte;
			if (pos == 6'd63) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end
		end else if (busy_q && !cmd.hinit && (rnd_q != 7'd64)) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
		end
		if (cmd.out_load) begin
			rsp_q.data_word <= cmd.out_zero ? 64'd0 : (dig_w[2'd3 - cmd.idx[1:0]] & keep);
			rsp_q.valid_bytes <= cmd.out_vb;
			rsp_q.final_res <= cmd.out_final;
			rsp_q.status <= cmd.out_status;
		end
	end

	assign sts.busy = busy_q;
	assign sts.pos = pos;
	assign sts.out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

	`HSP_ASSERT_IMP(a_feed_idle, cmd.feed, !busy_q)
	`HSP_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid_q || !rsp_stall)
	`HSP_ASSERT_NXT(a_blk_start, cmd.feed && !cmd.hinit && (pos == 6'd63), busy_q && (rnd_q == 7'd0))
endmodule

// File: src/hmac_sha256_tls_prf.sv
// Top level of the HMAC-SHA256 and TLS 1.2 PRF engine.
// Requests arrive one byte at a time on req (opcode, data_byte, last) with req_valid and
// req_stall; a request is taken at a clock edge with req_valid high and req_stall low.
// Opcode 0 bytes build the key, opcode 1 bytes carry the message or label and seed.
// Results leave on rsp as 64-bit words with a byte count, a final flag and a status bit.
// Registers mode and output_length are written through cfg_we, cfg_index and cfg_data.
// Each request occupies the engine until it is done; every 64 bytes hashed pass through
// the shared round unit, which runs one SHA-256 round per cycle. An HMAC tag follows the
// last message byte after three or four more blocks plus byte feeding. In PRF mode each
// 32-byte chunk costs two HMAC passes of at least four blocks each.
// The sequencer streams every byte, padding included, through one round unit.
// Reset clears the key to all zero, sets mode to 0 and output_length to 48.
// When rsp_stall is high the held result stays on rsp and the engine waits; requests
// are not taken while a run's results are produced, though the next request may be
// taken while the last result of the run is still held.
module hmac_sha256_tls_prf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [8:0]    cfg_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  hsp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hsp_pkg::rsp_t rsp
);
	import hsp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_opcode (req.opcode),
		.req_last   (req.last),
		.sts        (sts),
		.cmd        (cmd)
	);

	hsp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);
endmodule
